FILE: hw/rtl/qxmm_pkg.sv
// Package for the quad X motor mixer: payload structs, config struct, register indexes.
// No dependencies.
package qxmm_pkg;

  typedef struct packed {
    logic signed [31:0] lift_force;
    logic signed [31:0] roll_torque;
    logic signed [31:0] pitch_torque;
    logic signed [31:0] yaw_torque;
  } cmd_t;

  typedef struct packed {
    logic [19:0] speed_front_left;
    logic [19:0] speed_front_right;
    logic [19:0] speed_rear_left;
    logic [19:0] speed_rear_right;
  } res_t;

  typedef struct packed {
    logic [23:0] inv_arm_x;
    logic [23:0] inv_arm_y;
    logic [31:0] lift_to_drag_ratio;
    logic [31:0] inv_lift_coefficient;
    logic [19:0] speed_floor;
    logic [19:0] speed_ceiling;
  } cfg_t;

  localparam logic [2:0] REG_INV_ARM_X  = 3'd0;
  localparam logic [2:0] REG_INV_ARM_Y  = 3'd1;
  localparam logic [2:0] REG_LTD_RATIO  = 3'd2;
  localparam logic [2:0] REG_INV_LIFT   = 3'd3;
  localparam logic [2:0] REG_MIN_SPEED  = 3'd4;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd5;

  localparam int SQRT_STEPS = 21;   // root bits of a 41-bit radicand
  localparam logic [40:0] SQ_CAP = 41'h100_0000_0000;

endpackage

FILE: hw/rtl/qxmm_mix.sv
// Mixer front end: torque scaling, rotor sums, thrust times inverse lift coefficient.
// Depends on qxmm_pkg.
module qxmm_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  qxmm_pkg::cmd_t     cmd,
  input  qxmm_pkg::cfg_t     cfg,
  output logic               out_valid,
  output logic [3:0][40:0]   w2
);
  // stage 1: torque products
  logic              v1;
  logic signed [56:0] roll_p, pitch_p;
  logic signed [64:0] yaw_p;
  logic signed [31:0] thrust1;
  // stage 2: sums
  logic              v2;
  logic [3:0][47:0]  t2;
  // stage 3: partial products
  logic              v3;
  logic [3:0][55:0]  hp3;
  logic [3:0][55:0]  lp3;

  logic signed [48:0] roll_s, pitch_s, yaw_s;
  logic signed [50:0] sum [4];

  always_comb begin
    roll_s  = 49'($signed(roll_p[56:16]));
    pitch_s = 49'($signed(pitch_p[56:16]));
    yaw_s   = yaw_p[64:16];
    sum[0] = 51'(thrust1) + 51'(roll_s) - 51'(pitch_s) + 51'(yaw_s);
    sum[1] = 51'(thrust1) - 51'(roll_s) - 51'(pitch_s) - 51'(yaw_s);
    sum[2] = 51'(thrust1) + 51'(roll_s) + 51'(pitch_s) - 51'(yaw_s);
    sum[3] = 51'(thrust1) - 51'(roll_s) + 51'(pitch_s) + 51'(yaw_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; out_valid <= v3;
    end
    roll_p  <= cmd.roll_torque  * $signed({1'b0, cfg.inv_arm_y});
    pitch_p <= cmd.pitch_torque * $signed({1'b0, cfg.inv_arm_x});
    yaw_p   <= cmd.yaw_torque   * $signed({1'b0, cfg.lift_to_drag_ratio});
    thrust1 <= cmd.lift_force[31] ? 32'sd0 : cmd.lift_force;
    for (int i = 0; i < 4; i++) begin
      t2[i] <= (sum[i][50] || sum[i] == '0) ? 48'd0 : sum[i][49:2];
      hp3[i] <= 56'(t2[i][47:24]) * 56'(cfg.inv_lift_coefficient);
      lp3[i] <= 56'(t2[i][23:0]) * 56'(cfg.inv_lift_coefficient);
    end
    for (int i = 0; i < 4; i++) begin
      if (hp3[i] >= 56'(1 << 24)) begin
        w2[i] <= qxmm_pkg::SQ_CAP;
      end else begin
        logic [56:0] prod;
        prod = {hp3[i][32:0], 24'd0} + 57'(lp3[i]);
        w2[i] <= (prod[56:8] > 49'(qxmm_pkg::SQ_CAP)) ? qxmm_pkg::SQ_CAP : prod[48:8];
      end
    end
  end
endmodule

FILE: hw/rtl/qxmm_sqrt.sv
// Pipelined integer square root, one result bit per stage, with speed clamp.
// Depends on qxmm_pkg.
module qxmm_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [40:0]      radicand,
  input  logic [19:0]      min_speed,
  input  logic [19:0]      max_speed,
  output logic             out_valid,
  output logic [19:0]      speed
);
  localparam int N = qxmm_pkg::SQRT_STEPS;
  logic [N:0]            v;
  logic [N:0][41:0]      rem;
  logic [N:0][41:0]      rad;
  logic [N:0][20:0]      root;

  always_comb begin
    v[0] = in_valid;
    rad[0] = {1'b0, radicand};
    rem[0] = '0;
    root[0] = '0;
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [41:0] trial;
    logic [41:0] cur;
    always_comb begin
      cur = {rem[s][39:0], rad[s][41:40]};
      trial = {19'd0, root[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else v[s+1] <= v[s];
      rad[s+1] <= {rad[s][39:0], 2'b00};
      if (cur >= trial) begin
        rem[s+1] <= cur - trial;
        root[s+1] <= {root[s][19:0], 1'b1};
      end else begin
        rem[s+1] <= cur;
        root[s+1] <= {root[s][19:0], 1'b0};
      end
    end
  end

  logic [20:0] lo;
  always_comb begin
    lo = (root[N] < 21'(min_speed)) ? 21'(min_speed) : root[N];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v[N];
    speed <= (lo > 21'(max_speed)) ? max_speed : lo[19:0];
  end
endmodule

FILE: hw/rtl/quad_x_motor_mixer.sv
// Top level of the quad X motor mixer: config registers, mixer, four root units.
// Depends on qxmm_pkg, qxmm_mix, qxmm_sqrt.
//
// Usage: drive cmd and pulse start while busy is low; busy is always low, so a
// wrench beat may be issued every clock. Throughput is one command per cycle.
// From start to the done strobe a command passes four mixer stages (torque
// multiply, rotor sums, thrust partial products, product merge and cap), then
// 21 root stages that each settle one speed bit, then a clamp register.
// done is high for one cycle with res; the receiver cannot stall and each
// result must be taken in that cycle.
// Config writes: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high, indexes beyond the list are dropped. Write only while idle.
// Synchronous reset empties the pipeline and loads the register defaults.
module quad_x_motor_mixer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  qxmm_pkg::cmd_t  cmd,
  output logic            done,
  output qxmm_pkg::res_t  res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  qxmm_pkg::cfg_t cfg;
  logic           mix_valid;
  logic [3:0][40:0] w2;
  logic [3:0]     sq_valid;
  logic [3:0][19:0] spd;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_arm_x <= 24'd284939;
      cfg.inv_arm_y <= 24'd284939;
      cfg.lift_to_drag_ratio <= 32'd3481600;
      cfg.inv_lift_coefficient <= 32'd30117647;
      cfg.speed_floor <= 20'd0;
      cfg.speed_ceiling <= 20'd281600;
    end else if (cfg_valid) begin
      case (cfg_index)
        qxmm_pkg::REG_INV_ARM_X: cfg.inv_arm_x <= cfg_data[23:0];
        qxmm_pkg::REG_INV_ARM_Y: cfg.inv_arm_y <= cfg_data[23:0];
        qxmm_pkg::REG_LTD_RATIO: cfg.lift_to_drag_ratio <= cfg_data;
        qxmm_pkg::REG_INV_LIFT:  cfg.inv_lift_coefficient <= cfg_data;
        qxmm_pkg::REG_MIN_SPEED: cfg.speed_floor <= cfg_data[19:0];
        qxmm_pkg::REG_MAX_SPEED: cfg.speed_ceiling <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  qxmm_mix u_mix (
    .clk(clk), .rst(rst), .in_valid(start), .cmd(cmd), .cfg(cfg),
    .out_valid(mix_valid), .w2(w2)
  );

  for (genvar i = 0; i < 4; i++) begin : g_rotor
    qxmm_sqrt u_sqrt (
      .clk(clk), .rst(rst), .in_valid(mix_valid), .radicand(w2[i]),
      .min_speed(cfg.speed_floor), .max_speed(cfg.speed_ceiling),
      .out_valid(sq_valid[i]), .speed(spd[i])
    );
  end

  assign done = &sq_valid;
  assign res.speed_front_left  = spd[0];
  assign res.speed_front_right = spd[1];
  assign res.speed_rear_left   = spd[2];
  assign res.speed_rear_right  = spd[3];
endmodule
